[design/irq_controller_and_timer_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the interrupt controller and timer unit.
// ---------------------------------------------------------------------------
`ifndef IRQ_CONTROLLER_AND_TIMER_UNIT_ASSERT_SVH
`define IRQ_CONTROLLER_AND_TIMER_UNIT_ASSERT_SVH

// Checked outside of reset only.
`define ICTU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ICTU_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/ictu_pkg.sv]
// ---------------------------------------------------------------------------
// ictu_pkg
// Types and constants of the interrupt controller and timer unit.
// ---------------------------------------------------------------------------
package ictu_pkg;

   // event codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_ACK   = 2'd3;

   // register map (byte offsets)
   localparam logic [7:0] OFF_CACHE      = 8'h14;
   localparam logic [7:0] OFF_CONFIG     = 8'h24;
   localparam logic [7:0] OFF_TIMER_BASE = 8'h40;
   localparam logic [7:0] OFF_PRE_COUNT  = 8'h60;
   localparam logic [7:0] OFF_PRE_RELOAD = 8'h64;
   localparam logic [7:0] OFF_MASK       = 8'h90;
   localparam logic [7:0] OFF_PENDING    = 8'h94;
   localparam logic [7:0] OFF_FORCE      = 8'h98;
   localparam logic [7:0] OFF_CLEAR      = 8'h9c;

   // register within a timer's 16-byte slot
   localparam logic [3:0] TREG_COUNT   = 4'h0;
   localparam logic [3:0] TREG_RELOAD  = 4'h4;
   localparam logic [3:0] TREG_CONTROL = 4'h8;

   // timer control bits
   localparam int CTL_ENABLE = 0;
   localparam int CTL_AUTO   = 1;
   localparam int CTL_LOAD   = 2;

   localparam logic [15:0] LEVEL_MASK  = 16'hfffe;
   localparam logic [31:0] CONFIG_WORD = 32'h0070_0310;
   localparam logic [16:0] CACHE_MASK  = 17'h1000f;
   localparam logic [3:0]  CTRL_MASK   = 4'hb;
   localparam logic [15:0] PRE_RESET   = 16'hffff;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  reg_offset;
      logic [31:0] write_data;
      logic [3:0]  ack_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [3:0]  irq_level;
   } rsp_type;

endpackage

[design/irq_controller_and_timer_unit.sv]
// ---------------------------------------------------------------------------
// irq_controller_and_timer_unit
// Bus peripheral: 15-level interrupt controller plus prescaled timers.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel carries one transaction per event: register read, register
//    write, clock tick or interrupt acknowledge (req_data.func).
//  - rsp channel returns exactly one transaction per request: read_data for
//    a read (zero for other events) and the highest pending-or-forced,
//    unmasked interrupt level after the event (0 for none).
//  - The request lands in an input register, the event is applied to the
//    state and its response is written to the output register, and
//    rsp_valid rises from that register.
//  - Throughput, unstalled, is one transaction per cycle: a single pass of
//    decode, state update and priority encode between the two registers.
//  - When rsp_stall holds a response, one more request is taken into the
//    input register; after that req_stall rises until the response leaves.
//  - Reset (synchronous) empties both registers and loads the register file
//    with reset values: prescaler 0xffff, timer 0 count/reload all ones, else 0.
//  - Timer i sits at 0x40 + 16*i; a fixed register on the same offset wins.
// ---------------------------------------------------------------------------
module irq_controller_and_timer_unit
   import ictu_pkg::*;
#(
   parameter int NUM_TIMERS     = 2,
   parameter int TIMER_IRQ_BASE = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "irq_controller_and_timer_unit_assert.svh"

   // pipeline registers
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    s1_go, req_accept;

   // interrupt controller and prescaler state
   logic [15:0] pend_ff, pend_in;
   logic [15:0] force_ff, force_in;
   logic [15:0] mask_ff, mask_in;
   logic [15:0] pre_rld_ff, pre_rld_in;
   logic [15:0] pre_cnt_ff, pre_cnt_in;
   logic [16:0] cache_ff, cache_in;

   // decode of the transaction in the input register
   logic        ev_read, ev_write, ev_tick, ev_ack;
   logic        fixed_hit, pre_under;
   logic [7:0]  off, toff_rel;
   logic [31:0] wdata;
   logic [15:0] ack_bit;
   logic [15:0] tmr_irq_bits;
   logic [31:0] timer_rd;
   logic [15:0] active;
   logic [3:0]  level;
   logic [31:0] rd;

   // per-timer state
   logic [31:0] cnt_ff [NUM_TIMERS];
   logic [31:0] rld_ff [NUM_TIMERS];
   logic [3:0]  ctl_ff [NUM_TIMERS];
   logic [31:0] t_rd   [NUM_TIMERS];
   logic [15:0] t_irq  [NUM_TIMERS];

   // handshake: process whenever the output register is free or draining
   assign s1_go       = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_go;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);
   assign out_valid_in = s1_go || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign off      = s1_data_ff.reg_offset;
   assign wdata    = s1_data_ff.write_data;
   assign toff_rel = off - OFF_TIMER_BASE;
   assign ev_read  = s1_go && (s1_data_ff.func == FUNC_READ);
   assign ev_write = s1_go && (s1_data_ff.func == FUNC_WRITE);
   assign ev_tick  = s1_go && (s1_data_ff.func == FUNC_TICK);
   assign ev_ack   = s1_go && (s1_data_ff.func == FUNC_ACK);
   assign ack_bit  = 16'd1 << s1_data_ff.ack_level;
   assign pre_under = ev_tick && (pre_cnt_ff == 16'd0);

   always_comb begin
      fixed_hit = off inside {OFF_CACHE, OFF_CONFIG, OFF_PRE_COUNT, OFF_PRE_RELOAD,
                              OFF_MASK, OFF_PENDING, OFF_FORCE, OFF_CLEAR};
   end

   // timers
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      localparam logic [31:0] RST_VAL = (i == 0) ? 32'hffff_ffff : 32'h0;
      logic        sel, wr_cnt, wr_rld, wr_ctl, step, under;
      logic [31:0] cnt_in, rld_in;
      logic [3:0]  ctl_in;

      assign sel    = (off >= OFF_TIMER_BASE) && !fixed_hit && (toff_rel[7:4] == 4'(i));
      assign wr_cnt = ev_write && sel && (off[3:0] == TREG_COUNT);
      assign wr_rld = ev_write && sel && (off[3:0] == TREG_RELOAD);
      assign wr_ctl = ev_write && sel && (off[3:0] == TREG_CONTROL);
      assign step   = pre_under && ctl_ff[i][CTL_ENABLE];
      assign under  = step && (cnt_ff[i] == 32'd0);

      always_comb begin
         cnt_in = cnt_ff[i];
         rld_in = wr_rld ? wdata : rld_ff[i];
         ctl_in = wr_ctl ? (wdata[3:0] & CTRL_MASK) : ctl_ff[i];
         if (wr_cnt) begin
            cnt_in = wdata;
         end else if (wr_ctl && wdata[CTL_LOAD]) begin
            cnt_in = rld_ff[i];
         end else if (step) begin
            cnt_in = (under && ctl_ff[i][CTL_AUTO]) ? rld_ff[i] : cnt_ff[i] - 32'd1;
         end
      end

      always_comb begin
         t_rd[i] = 32'd0;
         if (sel) begin
            case (off[3:0])
               TREG_COUNT:   t_rd[i] = cnt_ff[i];
               TREG_RELOAD:  t_rd[i] = rld_ff[i];
               TREG_CONTROL: t_rd[i] = {28'd0, ctl_ff[i]};
               default:      t_rd[i] = 32'd0;
            endcase
         end
      end

      // levels above 15 have no pending bit
      if (TIMER_IRQ_BASE + i <= 15) begin : g_irq
         assign t_irq[i] = under ? (16'd1 << (TIMER_IRQ_BASE + i)) & LEVEL_MASK : 16'd0;
      end else begin : g_noirq
         assign t_irq[i] = 16'd0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= RST_VAL;
            rld_ff[i] <= RST_VAL;
            ctl_ff[i] <= 4'd0;
         end else begin
            cnt_ff[i] <= cnt_in;
            rld_ff[i] <= rld_in;
            ctl_ff[i] <= ctl_in;
         end
      end
   end

   always_comb begin
      tmr_irq_bits = 16'd0;
      timer_rd     = 32'd0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         tmr_irq_bits = tmr_irq_bits | t_irq[i];
         timer_rd     = timer_rd | t_rd[i];
      end
   end

   // interrupt controller, prescaler and cache word
   always_comb begin
      pend_in    = pend_ff | tmr_irq_bits;
      force_in   = force_ff;
      mask_in    = mask_ff;
      pre_rld_in = pre_rld_ff;
      cache_in   = cache_ff;
      pre_cnt_in = pre_cnt_ff;
      if (ev_tick) begin
         pre_cnt_in = pre_under ? pre_rld_ff : pre_cnt_ff - 16'd1;
      end
      if (ev_write) begin
         case (off)
            OFF_CACHE:      cache_in   = wdata[16:0] & CACHE_MASK;
            OFF_PRE_RELOAD: pre_rld_in = wdata[15:0];
            OFF_MASK:       mask_in    = wdata[15:0] & LEVEL_MASK;
            OFF_FORCE:      force_in   = wdata[15:0] & LEVEL_MASK;
            OFF_CLEAR:      pend_in    = pend_ff & ~wdata[15:0] & LEVEL_MASK;
            default:        ;
         endcase
      end
      // acknowledge clears the forced bit first, else the pending bit
      if (ev_ack) begin
         if ((force_ff & ack_bit) != 16'd0) begin
            force_in = force_ff & ~ack_bit;
         end else begin
            pend_in = pend_ff & ~ack_bit;
         end
      end
   end

   // read data
   always_comb begin
      rd = 32'd0;
      if (ev_read) begin
         case (off)
            OFF_CACHE:      rd = {15'd0, cache_ff};
            OFF_CONFIG:     rd = CONFIG_WORD;
            OFF_PRE_COUNT:  rd = {16'd0, pre_cnt_ff};
            OFF_PRE_RELOAD: rd = {16'd0, pre_rld_ff};
            OFF_MASK:       rd = {16'd0, mask_ff};
            OFF_PENDING:    rd = {16'd0, pend_ff};
            OFF_FORCE:      rd = {16'd0, force_ff};
            OFF_CLEAR:      rd = 32'd0;
            default:        rd = timer_rd;
         endcase
      end
   end

   // priority encode on the post-event state, highest level wins
   always_comb begin
      active = (pend_in | force_in) & mask_in & LEVEL_MASK;
      level  = 4'd0;
      for (int l = 1; l < 16; l++) begin
         if (active[l]) begin
            level = 4'(l);
         end
      end
      out_data_in.read_data = rd;
      out_data_in.irq_level = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 16'd0;
         force_ff     <= 16'd0;
         mask_ff      <= 16'd0;
         pre_rld_ff   <= PRE_RESET;
         pre_cnt_ff   <= PRE_RESET;
         cache_ff     <= 17'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         force_ff     <= force_in;
         mask_ff      <= mask_in;
         pre_rld_ff   <= pre_rld_in;
         pre_cnt_ff   <= pre_cnt_in;
         cache_ff     <= cache_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_go) begin
         out_data_ff <= out_data_in;
      end
   end

   // level 0 never holds a pending, forced or mask bit
   `ICTU_ASSERT_ALWAYS(a_level0_clear,
      reset || (pend_ff[0] == 1'b0 && force_ff[0] == 1'b0 && mask_ff[0] == 1'b0),
      "level 0 bit set in interrupt controller")
   // a processed transaction always leaves a response in the output register
   `ICTU_ASSERT(a_go_fills_out, s1_go |=> out_valid_ff,
      "processed transaction produced no response")
   // a held transaction stays in the input register unchanged
   `ICTU_ASSERT(a_s1_hold, (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_data_ff)),
      "held transaction lost or changed in input register")

endmodule

[sim/irq_controller_and_timer_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_controller_and_timer_unit_checker
// Watches both channels, predicts every response from its own copy of the
// register file and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module irq_controller_and_timer_unit_checker
   import ictu_pkg::*;
#(
   parameter int NUM_TIMERS     = 2,
   parameter int TIMER_IRQ_BASE = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_owed
);

   logic [15:0] irq_pending, irq_forced, irq_mask;
   logic [15:0] pre_reload, pre_count;
   logic [31:0] tmr_count  [NUM_TIMERS];
   logic [31:0] tmr_reload [NUM_TIMERS];
   logic [3:0]  tmr_ctrl   [NUM_TIMERS];
   logic [16:0] cache_word;

   rsp_type owed_q [$];
   int      mismatches = 0;

   // timer slot behind an offset; fixed registers are decoded first
   function automatic logic timer_hit(input logic [7:0] off, output int slot);
      slot = (int'(off) - int'(OFF_TIMER_BASE)) >>> 4;
      return slot >= 0 && slot < NUM_TIMERS;
   endfunction

   // applies one event to the register file, returns the response it owes
   function automatic rsp_type apply_event(input req_type r);
      rsp_type     o;
      int          slot;
      logic [15:0] active;
      o = '0;
      case (r.func)
         FUNC_READ: begin
            case (r.reg_offset)
               OFF_CACHE:      o.read_data = 32'(cache_word);
               OFF_CONFIG:     o.read_data = CONFIG_WORD;
               OFF_PRE_COUNT:  o.read_data = 32'(pre_count);
               OFF_PRE_RELOAD: o.read_data = 32'(pre_reload);
               OFF_MASK:       o.read_data = 32'(irq_mask);
               OFF_PENDING:    o.read_data = 32'(irq_pending);
               OFF_FORCE:      o.read_data = 32'(irq_forced);
               OFF_CLEAR:      o.read_data = '0;
               default: begin
                  if (timer_hit(r.reg_offset, slot)) begin
                     case (r.reg_offset[3:0])
                        TREG_COUNT:   o.read_data = tmr_count[slot];
                        TREG_RELOAD:  o.read_data = tmr_reload[slot];
                        TREG_CONTROL: o.read_data = 32'(tmr_ctrl[slot]);
                        default: ;
                     endcase
                  end
               end
            endcase
         end
         FUNC_WRITE: begin
            case (r.reg_offset)
               OFF_CACHE:      cache_word = r.write_data[16:0] & CACHE_MASK;
               OFF_CONFIG, OFF_PRE_COUNT, OFF_PENDING: ;
               OFF_PRE_RELOAD: pre_reload = r.write_data[15:0];
               OFF_MASK:       irq_mask = r.write_data[15:0] & LEVEL_MASK;
               OFF_FORCE:      irq_forced = r.write_data[15:0] & LEVEL_MASK;
               OFF_CLEAR:      irq_pending &= ~r.write_data[15:0] & LEVEL_MASK;
               default: begin
                  if (timer_hit(r.reg_offset, slot)) begin
                     case (r.reg_offset[3:0])
                        TREG_COUNT:  tmr_count[slot] = r.write_data;
                        TREG_RELOAD: tmr_reload[slot] = r.write_data;
                        TREG_CONTROL: begin
                           if (r.write_data[CTL_LOAD])
                              tmr_count[slot] = tmr_reload[slot];
                           tmr_ctrl[slot] = r.write_data[3:0] & CTRL_MASK;
                        end
                        default: ;
                     endcase
                  end
               end
            endcase
         end
         FUNC_TICK: begin
            if (pre_count != 16'd0) begin
               pre_count = pre_count - 16'd1;
            end else begin
               pre_count = pre_reload;
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (tmr_ctrl[i][CTL_ENABLE]) begin
                     tmr_count[i] = tmr_count[i] - 32'd1;
                     if (tmr_count[i] == '1) begin
                        // levels above 15 have no pending bit
                        if (TIMER_IRQ_BASE + i <= 15)
                           irq_pending[TIMER_IRQ_BASE + i] = 1'b1;
                        if (tmr_ctrl[i][CTL_AUTO])
                           tmr_count[i] = tmr_reload[i];
                     end
                  end
               end
            end
         end
         default: begin
            // acknowledge: a forced bit shadows the pending one
            if (irq_forced[r.ack_level])
               irq_forced[r.ack_level] = 1'b0;
            else
               irq_pending[r.ack_level] = 1'b0;
         end
      endcase
      active = (irq_pending | irq_forced) & irq_mask & LEVEL_MASK;
      for (int l = 1; l < 16; l++)
         if (active[l]) o.irq_level = 4'(l);
      return o;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns  %s: expected %h, got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         irq_pending = '0;
         irq_forced  = '0;
         irq_mask    = '0;
         pre_reload  = PRE_RESET;
         pre_count   = PRE_RESET;
         cache_word  = '0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_count[i]  = '0;
            tmr_reload[i] = '0;
            tmr_ctrl[i]   = '0;
         end
         tmr_count[0]  = '1;
         tmr_reload[0] = '1;
         owed_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               note_mismatch("transaction with none owed, read_data", '0,
                             rsp_data.read_data);
            end else begin
               want = owed_q.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  note_mismatch("read_data", want.read_data, rsp_data.read_data);
               if (rsp_data.irq_level !== want.irq_level)
                  note_mismatch("irq_level", 32'(want.irq_level),
                                32'(rsp_data.irq_level));
            end
         end
         if (req_valid && !req_stall)
            owed_q.push_back(apply_event(req_data));
      end
      results_owed   <= owed_q.size();
      mismatch_count <= mismatches;
   end

endmodule

[sim/irq_controller_and_timer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_controller_and_timer_unit_tb
// Drives register reads, writes, clock ticks and interrupt acknowledges into
// the peripheral in random bursts against a randomly stalling receiver; a
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module irq_controller_and_timer_unit_tb;
   import ictu_pkg::*;

   localparam int NUM_TIMERS     = 2;
   localparam int TIMER_IRQ_BASE = 8;

   // byte distance between two timer slots
   localparam logic [7:0] SLOT_STRIDE = 8'h10;
   localparam logic [7:0] TMR0_BASE   = OFF_TIMER_BASE;
   localparam logic [7:0] TMR1_BASE   = OFF_TIMER_BASE + SLOT_STRIDE;

   localparam int RANDOM_ITEMS = 1325;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_total;
   int results_owed;

   // transactions left in the current sender burst
   int burst_left = 0;

   irq_controller_and_timer_unit #(
      .NUM_TIMERS     (NUM_TIMERS),
      .TIMER_IRQ_BASE (TIMER_IRQ_BASE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   irq_controller_and_timer_unit_checker #(
      .NUM_TIMERS     (NUM_TIMERS),
      .TIMER_IRQ_BASE (TIMER_IRQ_BASE)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_total),
      .results_owed   (results_owed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver back-pressure: when the stall timer runs out, pick a mode - no
   // stall, light random, heavy random or a rotating bit pattern - so stalls
   // land on every phase of the pipeline, with clean stretches in between.
   int         stall_mode  = 0;
   int         stall_timer = 0;
   logic [7:0] stall_pattern = '0;

   always @(posedge clock) begin
      logic next_stall;
      if (stall_timer == 0) begin
         stall_mode    = $urandom_range(0, 3);
         stall_timer   = $urandom_range(20, 120);
         stall_pattern = 8'($urandom);
      end
      stall_timer--;
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      case (stall_mode)
         0:       next_stall = 1'b0;
         1:       next_stall = ($urandom_range(0, 7) == 0);
         2:       next_stall = 1'($urandom_range(0, 1));
         default: next_stall = stall_pattern[0];
      endcase
      rsp_stall <= reset ? 1'b0 : next_stall;
   end

   function automatic req_type make_req(input logic [1:0] func, input logic [7:0] off,
                                        input logic [31:0] data, input logic [3:0] lvl);
      req_type r;
      r.func       = func;
      r.reg_offset = off;
      r.write_data = data;
      r.ack_level  = lvl;
      return r;
   endfunction

   // Random event. Offsets mostly hit mapped registers; writes are shaped
   // toward small counts and reloads, enable mostly set, a short prescaler
   // and sparse forcing.
   function automatic req_type random_event();
      req_type r;
      int      roll;
      r.write_data = $urandom;
      r.ack_level  = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
         r.reg_offset = 8'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 13))
            0:       r.reg_offset = OFF_CACHE;
            1:       r.reg_offset = OFF_CONFIG;
            2:       r.reg_offset = TMR0_BASE + TREG_COUNT;
            3:       r.reg_offset = TMR0_BASE + TREG_RELOAD;
            4:       r.reg_offset = TMR0_BASE + TREG_CONTROL;
            5:       r.reg_offset = TMR1_BASE + TREG_COUNT;
            6:       r.reg_offset = TMR1_BASE + TREG_RELOAD;
            7:       r.reg_offset = TMR1_BASE + TREG_CONTROL;
            8:       r.reg_offset = OFF_PRE_COUNT;
            9:       r.reg_offset = OFF_PRE_RELOAD;
            10:      r.reg_offset = OFF_MASK;
            11:      r.reg_offset = OFF_PENDING;
            12:      r.reg_offset = OFF_FORCE;
            default: r.reg_offset = OFF_CLEAR;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 35)      r.func = FUNC_TICK;
      else if (roll < 60) r.func = FUNC_READ;
      else if (roll < 85) r.func = FUNC_WRITE;
      else                r.func = FUNC_ACK;

      if (r.func == FUNC_WRITE) begin
         case (r.reg_offset)
            // keep the prescaler short: a large reload would stall the timers
            OFF_PRE_RELOAD: r.write_data[15:0] = 16'($urandom_range(0, 3));
            OFF_FORCE: begin
               if ($urandom_range(0, 3) != 0) r.write_data = '0;
               else                           r.write_data &= $urandom;
            end
            TMR0_BASE + TREG_CONTROL, TMR1_BASE + TREG_CONTROL:
               r.write_data[CTL_ENABLE] = ($urandom_range(0, 3) != 0);
            TMR0_BASE + TREG_COUNT, TMR0_BASE + TREG_RELOAD,
            TMR1_BASE + TREG_COUNT, TMR1_BASE + TREG_RELOAD:
               if ($urandom_range(0, 3) != 0) r.write_data = $urandom_range(0, 6);
            default: ;
         endcase
      end
      return r;
   endfunction

   // One transaction. A new burst may open with an idle gap; valid is only
   // lowered when a gap really follows, so it never drops and rises within
   // one time step.
   task automatic send(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: register map corners, forcing, acknowledge, timers ----
      send(make_req(FUNC_READ,  OFF_CONFIG,     32'hffff_ffff, 4'd15));
      send(make_req(FUNC_READ,  8'h00,          32'h0,         4'd0));
      send(make_req(FUNC_READ,  8'hff,          32'hffff_ffff, 4'd15));
      send(make_req(FUNC_WRITE, OFF_CONFIG,     32'hffff_ffff, 4'd0));
      send(make_req(FUNC_WRITE, OFF_PRE_COUNT,  32'hffff_ffff, 4'd0));
      send(make_req(FUNC_WRITE, OFF_PRE_RELOAD, 32'hffff_ffff, 4'd0));
      send(make_req(FUNC_READ,  OFF_PRE_RELOAD, 32'h0,         4'd0));
      // short prescaler before any underflow can load the long one
      send(make_req(FUNC_WRITE, OFF_PRE_RELOAD, 32'h0000_0002, 4'd0));
      send(make_req(FUNC_WRITE, OFF_CACHE,      32'hffff_ffff, 4'd0));
      send(make_req(FUNC_READ,  OFF_CACHE,      32'h0,         4'd0));
      send(make_req(FUNC_WRITE, OFF_MASK,       32'hffff_ffff, 4'd0));
      send(make_req(FUNC_WRITE, OFF_FORCE,      32'hffff_ffff, 4'd0));
      // forced level wins, acknowledge drops it; level zero does nothing
      send(make_req(FUNC_ACK,   OFF_CLEAR,      32'h0,         4'd15));
      send(make_req(FUNC_ACK,   8'h00,          32'hffff_ffff, 4'd0));
      send(make_req(FUNC_WRITE, OFF_FORCE,      32'h0,         4'd0));
      send(make_req(FUNC_WRITE, OFF_PENDING,    32'hffff_ffff, 4'd0));
      send(make_req(FUNC_READ,  OFF_PENDING,    32'h0,         4'd0));
      send(make_req(FUNC_WRITE, TMR1_BASE + TREG_RELOAD,  32'd3,  4'd0));
      // enable, auto-reload and load from reload in one control write
      send(make_req(FUNC_WRITE, TMR1_BASE + TREG_CONTROL, 32'h7,  4'd0));
      send(make_req(FUNC_WRITE, TMR0_BASE + TREG_COUNT,   32'd1,  4'd0));
      send(make_req(FUNC_WRITE, TMR0_BASE + TREG_CONTROL, 32'hb,  4'd0));
      send(make_req(FUNC_TICK,  OFF_PRE_COUNT,  32'h0,         4'd0));
      send(make_req(FUNC_WRITE, OFF_CLEAR,      32'hffff_ffff, 4'd0));
      send(make_req(FUNC_READ,  OFF_CLEAR,      32'h0,         4'd0));
      send(make_req(FUNC_WRITE, TMR0_BASE + 8'hc, 32'hffff_ffff, 4'd0));
      wait_for_results();

      // ---- random traffic, with one more full pause halfway ----
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2)
            wait_for_results();
         send(random_event());
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_total == 0)
         $display("irq_controller_and_timer_unit: match");
      else
         $display("irq_controller_and_timer_unit: mismatch");
      $finish;
   end

   // Watchdog: a time limit far beyond the slowest legal run; reaching it reports a mismatch.
   initial begin
      #36_000_000;
      $display("irq_controller_and_timer_unit: mismatch");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/ictu_pkg.sv
design/irq_controller_and_timer_unit.sv
sim/irq_controller_and_timer_unit_checker.sv
sim/irq_controller_and_timer_unit_tb.sv
